>>> design/sfr_pkg.sv
// Shared constants and sideband types for the Schlick Fresnel reflectance pipeline.
`timescale 1ns / 1ps

package sfr_pkg;

   // Default fraction bits of the signed vector components
   localparam int SFR_VEC_FRAC_BITS = 14;

   // Fixed widths of the arithmetic
   localparam int SFR_ROOT_W = 17;            // root of a Q0.32 radicand, up to 65536
   localparam int SFR_RAD_W  = 33;            // radicand, up to 2^32
   localparam int SFR_R0_W   = 16;            // r0 quotient width
   localparam int SFR_R0_DW  = 35;            // r0 divisor width, (n1+n2)^2
   localparam int SFR_SIN_W  = 33;            // sin2 quotient width
   localparam int SFR_SIN_DW = 32;            // sin2 divisor width, n2^2

   localparam logic [16:0] SFR_ONE_Q16 = 17'h10000;

   // Per-word flags carried down the whole pipe
   typedef struct packed {
      logic        gt;       // n1 > n2
      logic        tir;      // total internal reflection
      logic        neg;      // cosine is negative
      logic [16:0] mag;      // saturated cosine magnitude, Q.16
   } sfr_flags_type;

   // Sideband through the r0 divider
   typedef struct packed {
      logic [48:0]   num;    // n1^2 * q
      logic [31:0]   n2sq;   // n2^2
      sfr_flags_type flags;
   } sfr_r0_side_type;

   // Sideband through the sin2 divider and the square root
   typedef struct packed {
      logic [15:0]   r0;
      sfr_flags_type flags;
   } sfr_post_side_type;

endpackage

>>> design/sfr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`timescale 1ns / 1ps

module sfr_div #(
   parameter int QW = sfr_pkg::SFR_R0_W,
   parameter int DW = sfr_pkg::SFR_R0_DW,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] num_hi,
   input  logic [QW-1:0] num_lo,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] quo,
   output logic [SW-1:0] out_side
);

   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [QW-1:0] low_ff   [QW];
   logic [QW-1:0] quo_ff   [QW];
   logic [DW-1:0] den_ff   [QW];
   logic [SW-1:0] side_ff  [QW];

   genvar k;
   for (k = 0; k < QW; k++) begin : g_step
      logic          vld_prev;
      logic [DW-1:0] rem_prev;
      logic [QW-1:0] low_prev;
      logic [QW-1:0] quo_prev;
      logic [DW-1:0] den_prev;
      logic [SW-1:0] side_prev;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = num_hi;
         assign low_prev  = num_lo;
         assign quo_prev  = '0;
         assign den_prev  = den;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign low_prev  = low_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // Bring down the next dividend bit and try the subtract
      assign trial = {rem_prev, low_prev[QW-1]};
      assign diff  = trial - {1'b0, den_prev};
      assign ge    = (trial >= {1'b0, den_prev});

      // Advance one quotient bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vld_prev;
         end
         if (en) begin
            rem_ff[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[k]  <= low_prev << 1;
            quo_ff[k]  <= {quo_prev[QW-2:0], ge};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quo       = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

>>> design/sfr_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband.
`timescale 1ns / 1ps

module sfr_sqrt #(
   parameter int SW = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [sfr_pkg::SFR_RAD_W-1:0]  rad,
   input  logic [SW-1:0]                  in_side,
   output logic                           out_valid,
   output logic [sfr_pkg::SFR_ROOT_W-1:0] root,
   output logic [SW-1:0]                  out_side
);

   localparam int RW = sfr_pkg::SFR_ROOT_W;
   localparam int VW = sfr_pkg::SFR_RAD_W;
   localparam int TW = VW + 3;

   logic          valid_ff [RW];
   logic [VW-1:0] rem_ff   [RW];
   logic [RW-1:0] root_ff  [RW];
   logic [SW-1:0] side_ff  [RW];

   genvar j;
   for (j = 0; j < RW; j++) begin : g_step
      localparam int B = RW - 1 - j;
      logic          vld_prev;
      logic [VW-1:0] rem_prev;
      logic [RW-1:0] root_prev;
      logic [SW-1:0] side_prev;
      logic [TW-1:0] term;
      logic [TW-1:0] diff;
      logic          ge;

      if (j == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = rad;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = valid_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
      assign term = (TW'(root_prev) << (B + 1)) + (TW'(1) << (2 * B));
      assign diff = TW'(rem_prev) - term;
      assign ge   = (TW'(rem_prev) >= term);

      // Advance one root bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= vld_prev;
         end
         if (en) begin
            rem_ff[j]  <= ge ? diff[VW-1:0] : rem_prev;
            root_ff[j] <= root_prev | (RW'(ge) << B);
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

>>> design/schlick_fresnel_reflectance_top.sv
// Top level of the Schlick Fresnel reflectance pipeline.
// One word enters per cycle unless the pipe holds; each word runs in order
// through the pipe: five front stages (dot product, cosine,
// squares, sin-squared numerator, total-internal-reflection test), a 16-stage
// divider for r0, a 33-stage divider for sin squared, a 17-stage square root,
// one stage that picks the cosine, four multiply stages for the fifth power,
// one multiply for the blend and the output register. The whole pipe holds
// while a result word waits under rsp_stall; req_stall is high exactly then.
`timescale 1ns / 1ps

module schlick_fresnel_reflectance_top #(
   parameter int VEC_FRAC_BITS = sfr_pkg::SFR_VEC_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_eye_x,
   input  logic signed [15:0] req_eye_y,
   input  logic signed [15:0] req_eye_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic        [15:0] req_index_from,
   input  logic        [15:0] req_index_to,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [16:0] rsp_reflectance,
   output logic               rsp_total_internal
);

   localparam int DOT_SHIFT = 2 * VEC_FRAC_BITS - 16;
   localparam int NPOW      = 4;

   logic en;

   // Pipe advances unless the output word is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------- stage 1: products, index fix ----------------
   logic               s1_valid_ff;
   logic signed [31:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic        [15:0] s1_n1_ff, s1_n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_px_ff <= req_eye_x * req_normal_x;
         s1_py_ff <= req_eye_y * req_normal_y;
         s1_pz_ff <= req_eye_z * req_normal_z;
         s1_n1_ff <= (req_index_from == 16'd0) ? 16'd1 : req_index_from;
         s1_n2_ff <= (req_index_to == 16'd0) ? 16'd1 : req_index_to;
      end
   end

   // ---------------- stage 2: dot sum, saturated cosine ----------------
   logic signed [32:0] dot;
   logic        [32:0] dot_abs;
   logic        [32:0] dot_shr;
   logic        [16:0] mag_in;

   assign dot     = 33'(s1_px_ff) + 33'(s1_py_ff) + 33'(s1_pz_ff);
   assign dot_abs = dot[32] ? 33'(-dot) : 33'(dot);
   assign dot_shr = dot_abs >> DOT_SHIFT;
   assign mag_in  = (dot_shr > 33'(sfr_pkg::SFR_ONE_Q16)) ? sfr_pkg::SFR_ONE_Q16
                                                          : dot_shr[16:0];

   logic        s2_valid_ff;
   logic        s2_neg_ff;
   logic [16:0] s2_mag_ff;
   logic [15:0] s2_n1_ff, s2_n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_neg_ff <= dot[32];
         s2_mag_ff <= mag_in;
         s2_n1_ff  <= s1_n1_ff;
         s2_n2_ff  <= s1_n2_ff;
      end
   end

   // ---------------- stage 3: squares ----------------
   logic        gt3;
   logic [15:0] diff3;
   logic [16:0] sum3;

   assign gt3   = s2_n1_ff > s2_n2_ff;
   assign diff3 = gt3 ? (s2_n1_ff - s2_n2_ff) : (s2_n2_ff - s2_n1_ff);
   assign sum3  = 17'(s2_n1_ff) + 17'(s2_n2_ff);

   logic          s3_valid_ff;
   sfr_pkg::sfr_flags_type s3_flags_ff;
   logic [33:0]   s3_magsq_ff;
   logic [31:0]   s3_n1sq_ff, s3_n2sq_ff, s3_dsq_ff;
   logic [33:0]   s3_ssq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_flags_ff.gt  <= gt3;
         s3_flags_ff.tir <= 1'b0;
         s3_flags_ff.neg <= s2_neg_ff;
         s3_flags_ff.mag <= s2_mag_ff;
         s3_magsq_ff     <= 34'(s2_mag_ff) * 34'(s2_mag_ff);
         s3_n1sq_ff      <= 32'(s2_n1_ff) * 32'(s2_n1_ff);
         s3_n2sq_ff      <= 32'(s2_n2_ff) * 32'(s2_n2_ff);
         s3_dsq_ff       <= 32'(diff3) * 32'(diff3);
         s3_ssq_ff       <= 34'(sum3) * 34'(sum3);
      end
   end

   // ---------------- stage 4: sin-squared numerator ----------------
   logic [33:0] one_minus_sq;
   logic [16:0] q4;

   assign one_minus_sq = 34'h1_0000_0000 - s3_magsq_ff;
   assign q4           = one_minus_sq[32:16];

   logic          s4_valid_ff;
   sfr_pkg::sfr_flags_type s4_flags_ff;
   logic [48:0]   s4_num_ff;
   logic [31:0]   s4_n2sq_ff, s4_dsq_ff;
   logic [33:0]   s4_ssq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (en) begin
         s4_flags_ff <= s3_flags_ff;
         s4_num_ff   <= 49'(s3_n1sq_ff) * 49'(q4);
         s4_n2sq_ff  <= s3_n2sq_ff;
         s4_dsq_ff   <= s3_dsq_ff;
         s4_ssq_ff   <= s3_ssq_ff;
      end
   end

   // ---------------- stage 5: total internal reflection test ----------------
   logic          s5_valid_ff;
   sfr_pkg::sfr_flags_type s5_flags_ff;
   logic [48:0]   s5_num_ff;
   logic [31:0]   s5_n2sq_ff, s5_dsq_ff;
   logic [33:0]   s5_ssq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (en) begin
         s5_flags_ff.gt  <= s4_flags_ff.gt;
         s5_flags_ff.neg <= s4_flags_ff.neg;
         s5_flags_ff.mag <= s4_flags_ff.mag;
         s5_flags_ff.tir <= s4_flags_ff.gt && (s4_num_ff > {1'b0, s4_n2sq_ff, 16'h0000});
         s5_num_ff       <= s4_num_ff;
         s5_n2sq_ff      <= s4_n2sq_ff;
         s5_dsq_ff       <= s4_dsq_ff;
         s5_ssq_ff       <= s4_ssq_ff;
      end
   end

   // ---------------- r0 divider ----------------
   sfr_pkg::sfr_r0_side_type r0_side_in, r0_side_out;
   logic                     r0_valid;
   logic [sfr_pkg::SFR_R0_W-1:0] r0_quo;

   always_comb begin
      r0_side_in.num   = s5_num_ff;
      r0_side_in.n2sq  = s5_n2sq_ff;
      r0_side_in.flags = s5_flags_ff;
   end

   sfr_div #(
      .QW (sfr_pkg::SFR_R0_W),
      .DW (sfr_pkg::SFR_R0_DW),
      .SW ($bits(sfr_pkg::sfr_r0_side_type))
   ) u_div_r0 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .num_hi    (sfr_pkg::SFR_R0_DW'(s5_dsq_ff)),
      .num_lo    ('0),
      .den       (sfr_pkg::SFR_R0_DW'(s5_ssq_ff)),
      .in_side   (r0_side_in),
      .out_valid (r0_valid),
      .quo       (r0_quo),
      .out_side  (r0_side_out)
   );

   // ---------------- sin-squared divider ----------------
   sfr_pkg::sfr_post_side_type sin_side_in, sin_side_out;
   logic                       sin_valid;
   logic [sfr_pkg::SFR_SIN_W-1:0] sin2;

   always_comb begin
      sin_side_in.r0    = r0_quo;
      sin_side_in.flags = r0_side_out.flags;
   end

   sfr_div #(
      .QW (sfr_pkg::SFR_SIN_W),
      .DW (sfr_pkg::SFR_SIN_DW),
      .SW ($bits(sfr_pkg::sfr_post_side_type))
   ) u_div_sin (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r0_valid),
      .num_hi    (r0_side_out.num[48:17]),
      .num_lo    ({r0_side_out.num[16:0], 16'h0000}),
      .den       (r0_side_out.n2sq),
      .in_side   (sin_side_in),
      .out_valid (sin_valid),
      .quo       (sin2),
      .out_side  (sin_side_out)
   );

   // ---------------- refracted cosine ----------------
   sfr_pkg::sfr_post_side_type sq_side_out;
   logic                       sq_valid;
   logic [sfr_pkg::SFR_ROOT_W-1:0] root;
   logic [sfr_pkg::SFR_RAD_W-1:0]  rad;

   assign rad = 33'h1_0000_0000 - sin2;

   sfr_sqrt #(
      .SW ($bits(sfr_pkg::sfr_post_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sin_valid),
      .rad       (rad),
      .in_side   (sin_side_out),
      .out_valid (sq_valid),
      .root      (root),
      .out_side  (sq_side_out)
   );

   // ---------------- pick cosine, t = 1 - c ----------------
   logic [17:0] t_in;

   always_comb begin
      if (sq_side_out.flags.gt) begin
         t_in = 18'(sfr_pkg::SFR_ONE_Q16) - 18'(root);
      end else if (sq_side_out.flags.neg) begin
         t_in = 18'(sfr_pkg::SFR_ONE_Q16) + 18'(sq_side_out.flags.mag);
      end else begin
         t_in = 18'(sfr_pkg::SFR_ONE_Q16) - 18'(sq_side_out.flags.mag);
      end
   end

   logic        pw_valid_ff [NPOW+1];
   logic [21:0] pw_p_ff     [NPOW+1];
   logic [17:0] pw_t_ff     [NPOW+1];
   logic [15:0] pw_r0_ff    [NPOW+1];
   logic        pw_tir_ff   [NPOW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_valid_ff[0] <= 1'b0;
      end else if (en) begin
         pw_valid_ff[0] <= sq_valid;
      end
      if (en) begin
         pw_p_ff[0]   <= 22'(t_in);
         pw_t_ff[0]   <= t_in;
         pw_r0_ff[0]  <= sq_side_out.r0;
         pw_tir_ff[0] <= sq_side_out.flags.tir;
      end
   end

   // ---------------- fifth power, one multiply per stage ----------------
   genvar m;
   for (m = 1; m <= NPOW; m++) begin : g_pow
      logic [39:0] prod;
      assign prod = 40'(pw_p_ff[m-1]) * 40'(pw_t_ff[m-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            pw_valid_ff[m] <= 1'b0;
         end else if (en) begin
            pw_valid_ff[m] <= pw_valid_ff[m-1];
         end
         if (en) begin
            pw_p_ff[m]   <= prod[37:16];
            pw_t_ff[m]   <= pw_t_ff[m-1];
            pw_r0_ff[m]  <= pw_r0_ff[m-1];
            pw_tir_ff[m] <= pw_tir_ff[m-1];
         end
      end
   end

   // ---------------- blend (1 - r0) * p ----------------
   logic [16:0] one_minus_r0;
   logic [38:0] blend;

   assign one_minus_r0 = sfr_pkg::SFR_ONE_Q16 - 17'(pw_r0_ff[NPOW]);
   assign blend        = 39'(one_minus_r0) * 39'(pw_p_ff[NPOW]);

   logic        bl_valid_ff;
   logic [22:0] bl_hi_ff;
   logic [15:0] bl_r0_ff;
   logic        bl_tir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bl_valid_ff <= 1'b0;
      end else if (en) begin
         bl_valid_ff <= pw_valid_ff[NPOW];
      end
      if (en) begin
         bl_hi_ff  <= blend[38:16];
         bl_r0_ff  <= pw_r0_ff[NPOW];
         bl_tir_ff <= pw_tir_ff[NPOW];
      end
   end

   // ---------------- output word: add r0, saturate ----------------
   logic [23:0] total;
   logic        rsp_valid_ff;
   logic [16:0] rsp_reflectance_ff;
   logic        rsp_total_internal_ff;

   assign total = 24'(bl_r0_ff) + 24'(bl_hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= bl_valid_ff;
      end
      if (en) begin
         if (bl_tir_ff) begin
            rsp_reflectance_ff    <= sfr_pkg::SFR_ONE_Q16;
            rsp_total_internal_ff <= 1'b1;
         end else begin
            rsp_reflectance_ff    <= (total > 24'(sfr_pkg::SFR_ONE_Q16))
                                     ? sfr_pkg::SFR_ONE_Q16 : total[16:0];
            rsp_total_internal_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reflectance    = rsp_reflectance_ff;
   assign rsp_total_internal = rsp_total_internal_ff;

   // ---------------- checks ----------------
   a_tir_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_internal |-> rsp_reflectance == sfr_pkg::SFR_ONE_Q16)
      else $error("total internal reflection word without full reflectance");

   a_refl_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reflectance <= sfr_pkg::SFR_ONE_Q16)
      else $error("reflectance above one");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output is free");

endmodule

>>> bench/tb.sv
// Self-checking bench for the Schlick Fresnel reflectance pipeline.
`timescale 1ns / 1ps

module tb;

   typedef struct {
      logic [16:0] reflectance;
      logic        total_internal;
   } fresnel_word_type;

   typedef struct {
      logic             typed;
      fresnel_word_type value;
   } typed_word_type;

   typedef struct {
      logic signed [15:0] ex, ey, ez, nx, ny, nz;
      logic        [15:0] n_from, n_to;
      logic               typed;
      logic        [16:0] refl;
      logic               tir;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [15:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic        [15:0] req_index_from = '0, req_index_to = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic        [16:0] rsp_reflectance;
   logic               rsp_total_internal;

   fresnel_word_type reflect_q[$];
   typed_word_type   typed_q[$];
   int          fail_count = 0;
   int          word_count = 0;
   int          tir_count = 0;
   int          tx_idle = 0;
   int          rx_idle = 0;
   int          hold_cycles = 0;

   schlick_fresnel_reflectance_top uut (.*);

   always #2 clock = ~clock;

   // integer square root, floor
   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // predict reflectance and flag for one hit
   function automatic fresnel_word_type schlick_predict(input stim_row_type w);
      fresnel_word_type r;
      longint      dot, c, t;
      logic [63:0] mag, n1, n2, q, num, den, sin2, d, s, r0, p, res;
      logic        neg;
      dot = longint'(w.ex) * w.nx + longint'(w.ey) * w.ny + longint'(w.ez) * w.nz;
      neg = dot < 0;
      mag = neg ? -dot : dot;
      mag = mag >> (2 * sfr_pkg::SFR_VEC_FRAC_BITS - 16);
      if (mag > 65536) mag = 65536;
      c = neg ? -longint'(mag) : longint'(mag);
      n1 = (w.n_from == 0) ? 1 : w.n_from;
      n2 = (w.n_to == 0) ? 1 : w.n_to;
      if (n1 > n2) begin
         q = ((64'd1 << 32) - mag * mag) >> 16;
         num = n1 * n1 * q;
         den = n2 * n2;
         if (num > den * 65536) begin
            r.reflectance = sfr_pkg::SFR_ONE_Q16;
            r.total_internal = 1'b1;
            return r;
         end
         sin2 = (num << 16) / den;
         c = longint'(floor_root((64'd1 << 32) - sin2));
      end
      d = (n1 > n2) ? n1 - n2 : n2 - n1;
      s = n1 + n2;
      r0 = ((d * d) << 16) / (s * s);
      t = 65536 - c;
      p = 65536;
      repeat (5) p = (p * t) >> 16;
      res = r0 + (((65536 - r0) * p) >> 16);
      if (res > 65536) res = 65536;
      r.reflectance = res[16:0];
      r.total_internal = 1'b0;
      return r;
   endfunction

   // offer one word and hold it until accepted; called at a falling edge
   task automatic send_word(input stim_row_type w);
      typed_word_type tw;
      tw.typed = w.typed;
      tw.value.reflectance = w.refl;
      tw.value.total_internal = w.tir;
      typed_q.push_back(tw);
      req_eye_x = w.ex; req_eye_y = w.ey; req_eye_z = w.ez;
      req_normal_x = w.nx; req_normal_y = w.ny; req_normal_z = w.nz;
      req_index_from = w.n_from; req_index_to = w.n_to;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if ($urandom_range(99) < tx_idle) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   function automatic logic signed [15:0] rand_comp();
      if ($urandom_range(99) < 20) return 16'($urandom);
      return 16'($urandom_range(32768) - 16384);
   endfunction

   function automatic logic [15:0] rand_index();
      int k;
      k = $urandom_range(99);
      if (k < 5) return 16'd0;
      if (k < 25) return 16'($urandom);
      return 16'($urandom_range(3000, 12000));
   endfunction

   function automatic stim_row_type rand_row();
      stim_row_type w;
      w.ex = rand_comp(); w.ey = rand_comp(); w.ez = rand_comp();
      w.nx = rand_comp(); w.ny = rand_comp(); w.nz = rand_comp();
      w.n_from = rand_index(); w.n_to = rand_index();
      w.typed = 1'b0; w.refl = '0; w.tir = 1'b0;
      return w;
   endfunction

   // receiver stall, with an optional long hold
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle);
      end
   end

   // record accepted words and check results
   always @(posedge clock) begin
      stim_row_type     w;
      typed_word_type   tw;
      fresnel_word_type got, want;
      if (!reset && req_valid && !req_stall) begin
         w.ex = req_eye_x; w.ey = req_eye_y; w.ez = req_eye_z;
         w.nx = req_normal_x; w.ny = req_normal_y; w.nz = req_normal_z;
         w.n_from = req_index_from; w.n_to = req_index_to;
         tw = typed_q.pop_front();
         want = tw.typed ? tw.value : schlick_predict(w);
         reflect_q.push_back(want);
         word_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.reflectance = rsp_reflectance;
         got.total_internal = rsp_total_internal;
         if (reflect_q.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            want = reflect_q.pop_front();
            if (got.total_internal) tir_count++;
            if (got.reflectance !== want.reflectance) begin
               $error("reflectance expected %0d actual %0d",
                      want.reflectance, got.reflectance);
               fail_count++;
            end
            if (got.total_internal !== want.total_internal) begin
               $error("total_internal expected %0d actual %0d",
                      want.total_internal, got.total_internal);
               fail_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #4_000_000;
      $display("schlick_fresnel_reflectance_top: mismatch");
      $finish;
   end

   initial begin
      stim_row_type table_rows[$];
      stim_row_type w;
      int      phase;
      // directed table: ex ey ez nx ny nz n1 n2 typed refl tir
      table_rows.push_back('{16384, 0, 0, 16384, 0, 0, 4096, 4096, 1, 0, 0});
      table_rows.push_back('{16384, 0, 0, 0, 16384, 0, 4096, 4096, 1, 65536, 0});
      table_rows.push_back('{16384, 0, 0, 0, 16384, 0, 65535, 1, 1, 65536, 1});
      table_rows.push_back('{-16384, 0, 0, 16384, 0, 0, 4096, 4096, 1, 65536, 0});
      table_rows.push_back('{16384, 0, 0, 0, 0, 16384, 0, 0, 1, 65536, 0});
      table_rows.push_back('{-32768, -32768, -32768, -32768, -32768, -32768,
                             65535, 65535, 0, 0, 0});
      table_rows.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 1, 65535, 0, 0, 0});
      table_rows.push_back('{32767, 0, 0, -32768, 0, 0, 4096, 6144, 0, 0, 0});
      table_rows.push_back('{16384, 0, 0, 16384, 0, 0, 6144, 4096, 0, 0, 0});
      table_rows.push_back('{11585, 0, 11585, 16384, 0, 0, 6144, 4096, 0, 0, 0});
      table_rows.push_back('{11585, 0, 11585, 16384, 0, 0, 4096, 6144, 0, 0, 0});
      table_rows.push_back('{0, 16384, 0, 0, 16384, 0, 0, 4096, 0, 0, 0});
      table_rows.push_back('{0, 8192, 0, 0, 16384, 0, 5461, 4096, 0, 0, 0});
      table_rows.push_back('{-16384, 0, 0, 16384, 0, 0, 6144, 4096, 0, 0, 0});
      table_rows.push_back('{0, 0, -16384, 0, 0, -16384, 4096, 0, 0, 0, 0});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i]) send_word(table_rows[i]);

      // three idle profiles; long receiver hold in the first
      for (phase = 0; phase < 3; phase++) begin
         req_valid = 1'b0;
         wait (reflect_q.size() == 0 && typed_q.size() == 0);
         @(negedge clock);
         tx_idle = (phase == 0) ? 26 : (phase == 1) ? 78 : 0;
         rx_idle = (phase == 0) ? 78 : (phase == 1) ? 26 : 0;
         if (phase == 0) hold_cycles = 400;
         repeat (262) begin
            w = rand_row();
            send_word(w);
         end
      end
      req_valid = 1'b0;

      wait (reflect_q.size() == 0 && typed_q.size() == 0);
      repeat (100) @(posedge clock);
      $display("covered %0d hit words, %0d with total internal reflection,", word_count,
               tir_count);
      $display("under three stall profiles and one long result hold");
      if (fail_count == 0)
         $display("schlick_fresnel_reflectance_top: match");
      else
         $display("schlick_fresnel_reflectance_top: mismatch");
      $finish;
   end
endmodule
